/* rtl/mrce_pkg.sv */
// ----------------------------------------------------------------------------
// mrce_pkg
// shared types and codes of the matrix row/column edit engine
// ----------------------------------------------------------------------------
package mrce_pkg;

  localparam int CMD_W = 4;
  localparam int IDX_W = 8;
  localparam int VAL_W = 32;
  localparam int POS_W = 3;
  localparam int ST_W  = 2;

  localparam logic [CMD_W-1:0] CMD_START     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ELEMENT   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ROW_BEF   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_ROW_AFT   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_COL_BEF   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_COL_AFT   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DEL_ROW   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DEL_COL   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SWAP_ROW  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_SWAP_COL  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_TRANSPOSE = 4'd10;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_BOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COPY,
    S_DRAIN,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_ROW,
    PEND_COL
  } pend_e;

  typedef enum logic [2:0] {
    CP_OPEN_ROW,
    CP_OPEN_COL,
    CP_DROP_ROW,
    CP_DROP_COL,
    CP_SWAP_ROW,
    CP_SWAP_COL,
    CP_TRANS
  } copy_e;

endpackage

/* rtl/mrce_ram.sv */
// ----------------------------------------------------------------------------
// mrce_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mrce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/matrix_row_col_edit_engine_core.sv */
// ----------------------------------------------------------------------------
// matrix_row_col_edit_engine_core
// start and element requests need no copy; a rearranging request copies the
// n cells between two ram banks, one cell a cycle, then emits the matrix at one
// cell a cycle while the output is not stalled
// bad-index, bound and empty emissions skip the copy; insert copies, then emits once its gap is filled
// reset: dimensions zero, load mode, no clearing pass, cell contents undefined
// ----------------------------------------------------------------------------
module matrix_row_col_edit_engine_core #(
  parameter int MAX_ROWS   = 8,
  parameter int MAX_COLS   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mrce_pkg::CMD_W-1:0]  command_i,
  input  logic [mrce_pkg::IDX_W-1:0]  index_a_i,
  input  logic [mrce_pkg::IDX_W-1:0]  index_b_i,
  input  logic signed [mrce_pkg::VAL_W-1:0] element_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [mrce_pkg::VAL_W-1:0] value_o,
  output logic [mrce_pkg::POS_W-1:0]  row_pos_o,
  output logic [mrce_pkg::POS_W-1:0]  col_pos_o,
  output logic                        last_o,
  output logic [mrce_pkg::ST_W-1:0]   status_o
);

  // sizes
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DIMW  = $clog2(MAXD + 1);
  localparam int NW    = 2 * DIMW + 1;
  localparam int FW    = $clog2(CELLS + 1);
  localparam int IW    = mrce_pkg::IDX_W;
  localparam int VW    = mrce_pkg::VAL_W;
  localparam int PW    = mrce_pkg::POS_W;
  localparam logic [FW-1:0]   FILL_FULL = FW'(CELLS);
  localparam logic [DIMW-1:0] LIM_ROWS  = DIMW'(MAX_ROWS);
  localparam logic [DIMW-1:0] LIM_COLS  = DIMW'(MAX_COLS);
  localparam logic [DIMW-1:0] DIM_ONE   = DIMW'(1);

  // control and matrix state
  mrce_pkg::state_e state_q, state_d;
  mrce_pkg::pend_e  pend_q, pend_d;
  mrce_pkg::copy_e  cop_q, cop_d;
  logic            bank_q, bank_d;
  logic [DIMW-1:0] rows_q, rows_d, cols_q, cols_d, scols_q, scols_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic [DIMW-1:0] pidx_q, pidx_d, p_q, p_d, q_q, q_d;
  logic            emit_after_q, emit_after_d;
  logic [mrce_pkg::ST_W-1:0] st_q, st_d;
  logic            force_q, force_d;

  // shared walk counters for copy and emission
  logic [DIMW-1:0] r_q, r_d, c_q, c_d;
  logic [AW-1:0]   k_q, k_d;
  logic            more_q, more_d;

  // result sideband, the value itself sits in the ram read register
  logic            ov_q, ov_d, olast_q, olast_d;
  logic [DIMW-1:0] orow_q, orow_d, ocol_q, ocol_d;

  // copy write pipe, issued in the cycle after the read
  logic            wv_q, wv_d, wgap_q, wgap_d;
  logic [AW-1:0]   wa_q, wa_d;

  // ram side
  logic                  lwe, cre;
  logic [AW-1:0]         lwa, cra;
  logic [DATA_WIDTH-1:0] lwd, cwd, rd0, rd1, rd_cur;

  // decode helpers
  logic            in_acc, n_zero, is_row, empty, adv, fin, gap, last_pos;
  logic [DIMW-1:0] cnt, lim, sr, sc;
  logic [NW-1:0]   n_cells, fill_addr, src_addr;
  logic [IW-1:0]   a8, b8;

  assign in_acc = in_valid_i && (state_q == mrce_pkg::S_IDLE);
  assign in_stall_o = (state_q != mrce_pkg::S_IDLE);

  assign n_cells = NW'(rows_q) * NW'(cols_q);
  assign n_zero  = (rows_q == '0) || (cols_q == '0);
  assign empty   = n_zero;
  assign a8      = index_a_i;
  assign b8      = index_b_i;

  assign is_row = (command_i == mrce_pkg::CMD_ROW_BEF) || (command_i == mrce_pkg::CMD_ROW_AFT) ||
                  (command_i == mrce_pkg::CMD_DEL_ROW) || (command_i == mrce_pkg::CMD_SWAP_ROW);
  assign cnt = is_row ? rows_q : cols_q;
  assign lim = is_row ? LIM_ROWS : LIM_COLS;

  // element narrowed or sign-extended to the stored width
  assign lwd = DATA_WIDTH'({{DATA_WIDTH{element_i[VW-1]}}, element_i});

  // gap fill address, row-major
  assign fill_addr = (pend_q == mrce_pkg::PEND_ROW) ?
                     NW'(pidx_q) * NW'(cols_q) + NW'(fill_q) :
                     NW'(fill_q) * NW'(cols_q) + NW'(pidx_q);

  // source cell of destination (r, c) for each rearrangement
  always_comb begin
    sr  = r_q;
    sc  = c_q;
    gap = 1'b0;
    case (cop_q)
      mrce_pkg::CP_OPEN_ROW: begin
        gap = (r_q == p_q);
        sr  = (r_q > p_q) ? r_q - 1'b1 : r_q;
      end
      mrce_pkg::CP_OPEN_COL: begin
        gap = (c_q == p_q);
        sc  = (c_q > p_q) ? c_q - 1'b1 : c_q;
      end
      mrce_pkg::CP_DROP_ROW: sr = (r_q >= p_q) ? r_q + 1'b1 : r_q;
      mrce_pkg::CP_DROP_COL: sc = (c_q >= p_q) ? c_q + 1'b1 : c_q;
      mrce_pkg::CP_SWAP_ROW: sr = (r_q == p_q) ? q_q : ((r_q == q_q) ? p_q : r_q);
      mrce_pkg::CP_SWAP_COL: sc = (c_q == p_q) ? q_q : ((c_q == q_q) ? p_q : c_q);
      mrce_pkg::CP_TRANS: begin
        sr = c_q;
        sc = r_q;
      end
      default: begin
        sr = r_q;
        sc = c_q;
      end
    endcase
  end

  assign src_addr = NW'(sr) * NW'(scols_q) + NW'(sc);
  assign last_pos = (r_q == rows_q - 1'b1) && (c_q == cols_q - 1'b1);
  assign adv      = !ov_q || !out_stall_i;
  assign fin      = empty || last_pos;

  always_comb begin
    state_d      = state_q;
    pend_d       = pend_q;
    cop_d        = cop_q;
    bank_d       = bank_q;
    rows_d       = rows_q;
    cols_d       = cols_q;
    scols_d      = scols_q;
    fill_d       = fill_q;
    pidx_d       = pidx_q;
    p_d          = p_q;
    q_d          = q_q;
    emit_after_d = emit_after_q;
    st_d         = st_q;
    force_d      = force_q;
    r_d          = r_q;
    c_d          = c_q;
    k_d          = k_q;
    more_d       = more_q;
    ov_d         = ov_q;
    olast_d      = olast_q;
    orow_d       = orow_q;
    ocol_d       = ocol_q;
    wv_d         = 1'b0;
    wgap_d       = wgap_q;
    wa_d         = wa_q;
    lwe          = 1'b0;
    lwa          = fill_q[AW-1:0];
    cre          = 1'b0;
    cra          = k_q;

    case (state_q)
      mrce_pkg::S_IDLE: begin
        if (in_acc && (command_i <= mrce_pkg::CMD_TRANSPOSE)) begin
          if (command_i == mrce_pkg::CMD_ELEMENT) begin
            if (pend_q == mrce_pkg::PEND_NONE) begin
              // plain load, ignored once the matrix is full
              if (NW'(fill_q) < n_cells) begin
                lwe    = 1'b1;
                fill_d = fill_q + 1'b1;
              end
            end else begin
              // filling the gap opened by an insert
              lwe    = 1'b1;
              lwa    = fill_addr[AW-1:0];
              fill_d = fill_q + 1'b1;
              if (NW'(fill_q) + 1'b1 >= NW'((pend_q == mrce_pkg::PEND_ROW) ? cols_q : rows_q))
                begin
                pend_d  = mrce_pkg::PEND_NONE;
                fill_d  = FILL_FULL;
                st_d    = mrce_pkg::ST_OK;
                force_d = 1'b0;
                state_d = mrce_pkg::S_EMIT;
              end
            end
          end else begin
            // any other request ends load mode and abandons a gap fill
            pend_d       = mrce_pkg::PEND_NONE;
            fill_d       = FILL_FULL;
            force_d      = 1'b0;
            emit_after_d = 1'b1;
            scols_d      = cols_q;
            st_d         = mrce_pkg::ST_OK;
            if (command_i == mrce_pkg::CMD_START) begin
              fill_d = '0;
              if ((a8 > IW'(MAX_ROWS)) || (b8 > IW'(MAX_COLS))) begin
                rows_d  = '0;
                cols_d  = '0;
                st_d    = mrce_pkg::ST_BOUND;
                force_d = 1'b1;
                state_d = mrce_pkg::S_EMIT;
              end else begin
                rows_d = DIMW'(a8);
                cols_d = DIMW'(b8);
              end
            end else if (command_i == mrce_pkg::CMD_TRANSPOSE) begin
              if ((rows_q > LIM_COLS) || (cols_q > LIM_ROWS)) begin
                st_d    = mrce_pkg::ST_BOUND;
                state_d = mrce_pkg::S_EMIT;
              end else begin
                rows_d  = cols_q;
                cols_d  = rows_q;
                cop_d   = mrce_pkg::CP_TRANS;
                state_d = n_zero ? mrce_pkg::S_EMIT : mrce_pkg::S_COPY;
              end
            end else if (n_zero) begin
              state_d = mrce_pkg::S_EMIT;
            end else if ((a8 == '0) || (a8 > IW'(cnt))) begin
              st_d    = mrce_pkg::ST_RANGE;
              state_d = mrce_pkg::S_EMIT;
            end else if (command_i <= mrce_pkg::CMD_COL_AFT) begin
              // insert: open a zeroed gap, then wait for its elements
              if (cnt >= lim) begin
                st_d    = mrce_pkg::ST_BOUND;
                state_d = mrce_pkg::S_EMIT;
              end else begin
                p_d = ((command_i == mrce_pkg::CMD_ROW_BEF) ||
                       (command_i == mrce_pkg::CMD_COL_BEF)) ?
                      DIMW'(a8 - 1'b1) : DIMW'(a8);
                pidx_d = ((command_i == mrce_pkg::CMD_ROW_BEF) ||
                          (command_i == mrce_pkg::CMD_COL_BEF)) ?
                         DIMW'(a8 - 1'b1) : DIMW'(a8);
                fill_d       = '0;
                emit_after_d = 1'b0;
                state_d      = mrce_pkg::S_COPY;
                if (is_row) begin
                  rows_d = rows_q + 1'b1;
                  cop_d  = mrce_pkg::CP_OPEN_ROW;
                  pend_d = mrce_pkg::PEND_ROW;
                end else begin
                  cols_d = cols_q + 1'b1;
                  cop_d  = mrce_pkg::CP_OPEN_COL;
                  pend_d = mrce_pkg::PEND_COL;
                end
              end
            end else if ((command_i == mrce_pkg::CMD_DEL_ROW) ||
                         (command_i == mrce_pkg::CMD_DEL_COL)) begin
              p_d = DIMW'(a8 - 1'b1);
              if (is_row) begin
                rows_d  = rows_q - 1'b1;
                cop_d   = mrce_pkg::CP_DROP_ROW;
                // last row gone: nothing to copy
                state_d = (rows_q == DIM_ONE) ? mrce_pkg::S_EMIT : mrce_pkg::S_COPY;
              end else begin
                cols_d  = cols_q - 1'b1;
                cop_d   = mrce_pkg::CP_DROP_COL;
                state_d = (cols_q == DIM_ONE) ? mrce_pkg::S_EMIT : mrce_pkg::S_COPY;
              end
            end else begin
              // swap
              if ((b8 == '0) || (b8 > IW'(cnt))) begin
                st_d    = mrce_pkg::ST_RANGE;
                state_d = mrce_pkg::S_EMIT;
              end else begin
                p_d     = DIMW'(a8 - 1'b1);
                q_d     = DIMW'(b8 - 1'b1);
                cop_d   = is_row ? mrce_pkg::CP_SWAP_ROW : mrce_pkg::CP_SWAP_COL;
                state_d = mrce_pkg::S_COPY;
              end
            end
          end
          // walk counters restart for whichever phase follows
          r_d    = '0;
          c_d    = '0;
          k_d    = '0;
          more_d = 1'b1;
        end
      end

      mrce_pkg::S_COPY: begin
        // read source cell, write destination in the next cycle
        cre    = !gap;
        cra    = src_addr[AW-1:0];
        wv_d   = 1'b1;
        wa_d   = k_q;
        wgap_d = gap;
        k_d    = k_q + 1'b1;
        if (c_q == cols_q - 1'b1) begin
          c_d = '0;
          r_d = r_q + 1'b1;
        end else begin
          c_d = c_q + 1'b1;
        end
        if (last_pos) begin
          state_d = mrce_pkg::S_DRAIN;
        end
      end

      mrce_pkg::S_DRAIN: begin
        // final copy write lands at this edge, new bank becomes current
        bank_d  = !bank_q;
        r_d     = '0;
        c_d     = '0;
        k_d     = '0;
        more_d  = 1'b1;
        state_d = emit_after_q ? mrce_pkg::S_EMIT : mrce_pkg::S_IDLE;
      end

      mrce_pkg::S_EMIT: begin
        if (adv) begin
          if (more_q) begin
            ov_d    = 1'b1;
            orow_d  = empty ? '0 : r_q;
            ocol_d  = empty ? '0 : c_q;
            olast_d = fin;
            cre     = !empty;
            cra     = k_q;
            k_d     = k_q + 1'b1;
            if (c_q == cols_q - 1'b1) begin
              c_d = '0;
              r_d = r_q + 1'b1;
            end else begin
              c_d = c_q + 1'b1;
            end
            if (fin) begin
              more_d = 1'b0;
            end
          end else begin
            ov_d    = 1'b0;
            state_d = mrce_pkg::S_IDLE;
          end
        end
      end

      default: state_d = mrce_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mrce_pkg::S_IDLE;
      pend_q       <= mrce_pkg::PEND_NONE;
      cop_q        <= mrce_pkg::CP_OPEN_ROW;
      bank_q       <= 1'b0;
      rows_q       <= '0;
      cols_q       <= '0;
      scols_q      <= '0;
      fill_q       <= '0;
      pidx_q       <= '0;
      p_q          <= '0;
      q_q          <= '0;
      emit_after_q <= 1'b0;
      st_q         <= mrce_pkg::ST_OK;
      force_q      <= 1'b0;
      r_q          <= '0;
      c_q          <= '0;
      k_q          <= '0;
      more_q       <= 1'b0;
      ov_q         <= 1'b0;
      wv_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_q       <= pend_d;
      cop_q        <= cop_d;
      bank_q       <= bank_d;
      rows_q       <= rows_d;
      cols_q       <= cols_d;
      scols_q      <= scols_d;
      fill_q       <= fill_d;
      pidx_q       <= pidx_d;
      p_q          <= p_d;
      q_q          <= q_d;
      emit_after_q <= emit_after_d;
      st_q         <= st_d;
      force_q      <= force_d;
      r_q          <= r_d;
      c_q          <= c_d;
      k_q          <= k_d;
      more_q       <= more_d;
      ov_q         <= ov_d;
      wv_q         <= wv_d;
    end
  end

  // sideband payload, no reset
  always_ff @(posedge clk_i) begin
    olast_q <= olast_d;
    orow_q  <= orow_d;
    ocol_q  <= ocol_d;
    wgap_q  <= wgap_d;
    wa_q    <= wa_d;
  end

  // two banks: current holds the matrix, the other takes a copy
  assign rd_cur = bank_q ? rd1 : rd0;
  assign cwd    = wgap_q ? '0 : rd_cur;

  mrce_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CELLS)
  ) u_bank0 (
    .clk_i  (clk_i),
    .we_i   (bank_q ? wv_q : lwe),
    .waddr_i(bank_q ? wa_q : lwa),
    .wdata_i(bank_q ? cwd : lwd),
    .re_i   (bank_q ? 1'b0 : cre),
    .raddr_i(cra),
    .rdata_o(rd0)
  );

  mrce_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CELLS)
  ) u_bank1 (
    .clk_i  (clk_i),
    .we_i   (bank_q ? lwe : wv_q),
    .waddr_i(bank_q ? lwa : wa_q),
    .wdata_i(bank_q ? lwd : cwd),
    .re_i   (bank_q ? cre : 1'b0),
    .raddr_i(cra),
    .rdata_o(rd1)
  );

  // outputs
  assign out_valid_o = ov_q;
  assign value_o     = empty ? '0 : VW'({{VW{rd_cur[DATA_WIDTH-1]}}, rd_cur});
  assign row_pos_o   = PW'(orow_q);
  assign col_pos_o   = PW'(ocol_q);
  assign last_o      = olast_q;
  assign status_o    = (empty && !force_q) ? mrce_pkg::ST_EMPTY : st_q;

  // checks
  a_out_in_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (state_q == mrce_pkg::S_EMIT))
    else $error("result valid outside emission");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && olast_q) |-> !more_q)
    else $error("cells left to emit after last");

  a_copy_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wv_q |-> ((state_q == mrce_pkg::S_COPY) || (state_q == mrce_pkg::S_DRAIN)))
    else $error("copy write outside copy phase");

  a_row_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == mrce_pkg::PEND_ROW) |-> (NW'(fill_q) < NW'(cols_q)))
    else $error("row gap fill beyond row length");

  a_col_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == mrce_pkg::PEND_COL) |-> (NW'(fill_q) < NW'(rows_q)))
    else $error("column gap fill beyond column length");

endmodule
